// ===== src/cacc_pkg.sv =====
// Shared types and constants for the complex accumulator.
package cacc_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    FUNC_LOAD = 3'd0,
    FUNC_ADD  = 3'd1,
    FUNC_SUB  = 3'd2,
    FUNC_MUL  = 3'd3,
    FUNC_DIV  = 3'd4
  } func_code_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] operand_real;
    logic signed [31:0] operand_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic               error;
    logic               saturated;
  } out_item_t;

  // Datapath operations requested by the controller.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_CAPTURE = 3'd1,
    OP_SIMPLE  = 3'd2,
    OP_PROD    = 3'd3,
    OP_SUM     = 3'd4,
    OP_DIVINIT = 3'd5,
    OP_DIVSTEP = 3'd6,
    OP_DIVDONE = 3'd7
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] prod_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       div_last;
    logic       den_zero;
  } dp_status_t;

endpackage

// ===== src/cacc_ctrl.sv =====
// Controller state machine that sequences the datapath for one item.
module cacc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output cacc_pkg::dp_cmd_t   cmd,
  input  cacc_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_PROD, S_SUM, S_DIVINIT, S_DIV, S_OUT
  } state_t;

  state_t     state;
  logic [1:0] psel;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.op = cacc_pkg::OP_NONE;
    cmd.prod_sel = psel;
    case (state)
      S_IDLE:    if (in_valid) cmd.op = cacc_pkg::OP_CAPTURE;
      S_DECODE: begin
        if (status.func == cacc_pkg::FUNC_MUL || status.func == cacc_pkg::FUNC_DIV) begin
          cmd.op = cacc_pkg::OP_NONE;
        end else begin
          cmd.op = cacc_pkg::OP_SIMPLE;
        end
      end
      S_PROD:    cmd.op = cacc_pkg::OP_PROD;
      S_SUM:     cmd.op = cacc_pkg::OP_SUM;
      S_DIVINIT: cmd.op = cacc_pkg::OP_DIVINIT;
      S_DIV:     cmd.op = status.div_last ? cacc_pkg::OP_DIVDONE : cacc_pkg::OP_DIVSTEP;
      default:   cmd.op = cacc_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      psel  <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_DECODE;
        S_DECODE: begin
          psel <= '0;
          if (status.func == cacc_pkg::FUNC_MUL || status.func == cacc_pkg::FUNC_DIV) begin
            state <= S_PROD;
          end else begin
            state <= S_OUT;
          end
        end
        S_PROD: begin
          psel <= psel + 2'd1;
          if (psel == 2'd3) state <= S_SUM;
        end
        S_SUM: begin
          if (status.func == cacc_pkg::FUNC_MUL || status.den_zero) begin
            state <= S_OUT;
          end else begin
            state <= S_DIVINIT;
          end
        end
        S_DIVINIT: state <= S_DIV;
        S_DIV: if (status.div_last) state <= S_OUT;
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/cacc_dp.sv =====
// Datapath: accumulator, shared multiplier and a two-lane restoring divider.
module cacc_dp #(
  parameter int WORD_BITS = cacc_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cacc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cacc_pkg::in_item_t   in_item,
  input  cacc_pkg::dp_cmd_t    cmd,
  output cacc_pkg::dp_status_t status,
  output cacc_pkg::out_item_t  out_item
);

  localparam int W   = WORD_BITS;
  localparam int PW  = 2 * W;          // one product
  localparam int SW  = 2 * W + 1;      // sum of two products
  localparam int DW  = SW + FRAC_BITS; // shifted dividend magnitude
  localparam int RW  = PW + 2;         // remainder with headroom
  localparam int CW  = $clog2(DW + 1);

  logic signed [W-1:0]  acc_r, acc_i, x_r, x_i;
  logic                 err;
  logic [2:0]           func;
  logic signed [PW-1:0] prod [4];
  logic signed [SW-1:0] num_r, num_i;
  logic [PW:0]          den;
  logic [DW-1:0]        dq_r, dq_i;
  logic [RW-1:0]        rem_r, rem_i;
  logic                 neg_r, neg_i;
  logic [CW-1:0]        cnt;
  logic                 sat;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  // Operand pairs for the multiplier, one product per cycle.
  logic signed [W-1:0]  ma, mb;
  logic signed [PW-1:0] mp;
  always_comb begin
    case (cmd.prod_sel)
      2'd0:    begin ma = acc_r; mb = x_r; end
      2'd1:    begin ma = acc_i; mb = x_i; end
      2'd2:    begin ma = acc_r; mb = x_i; end
      default: begin ma = acc_i; mb = x_r; end
    endcase
    mp = PW'(ma) * PW'(mb);
  end

  // Operand squares for the divisor use their own multipliers and are summed into den at product selects 0 and 1.
  logic signed [PW-1:0] xrr, xii;
  assign xrr = PW'(x_r) * PW'(x_r);
  assign xii = PW'(x_i) * PW'(x_i);

  // Saturation of a wide signed value to a word.
  function automatic logic [W:0] sat_w(input logic signed [DW:0] v);
    logic [W:0] r;
    if (v > DW'(WMAX) && !v[DW]) r = {1'b1, WMAX};
    else if (v < $signed({{(DW+1-W){1'b1}}, WMIN})) r = {1'b1, WMIN};
    else r = {1'b0, v[W-1:0]};
    return r;
  endfunction

  logic signed [W:0] s_r, s_i;
  logic [W:0]        sr_r, sr_i;
  logic signed [SW-1:0] pr, pi;
  logic [W:0]        mr_r, mr_i;
  always_comb begin
    if (func == cacc_pkg::FUNC_SUB) begin
      s_r = (W+1)'(acc_r) - (W+1)'(x_r);
      s_i = (W+1)'(acc_i) - (W+1)'(x_i);
    end else begin
      s_r = (W+1)'(acc_r) + (W+1)'(x_r);
      s_i = (W+1)'(acc_i) + (W+1)'(x_i);
    end
    sr_r = sat_w((DW+1)'(s_r));
    sr_i = sat_w((DW+1)'(s_i));
    pr = SW'(prod[0]) - SW'(prod[1]);
    pi = SW'(prod[2]) + SW'(prod[3]);
    mr_r = sat_w((DW+1)'(pr >>> FRAC_BITS));
    mr_i = sat_w((DW+1)'(pi >>> FRAC_BITS));
  end

  // One restoring step for each lane.
  logic [RW-1:0] tr_r, tr_i;
  logic          qb_r, qb_i;
  always_comb begin
    tr_r = {rem_r[RW-2:0], dq_r[DW-1]};
    tr_i = {rem_i[RW-2:0], dq_i[DW-1]};
    qb_r = tr_r >= RW'(den);
    qb_i = tr_i >= RW'(den);
  end

  function automatic logic [W:0] div_fin(input logic [DW-1:0] q, input logic neg);
    logic [W:0] r;
    if (neg) begin
      if (q > DW'(WMAX) + DW'(1)) r = {1'b1, WMIN};
      else r = {1'b0, W'(-q)};
    end else begin
      if (q > DW'(WMAX)) r = {1'b1, WMAX};
      else r = {1'b0, q[W-1:0]};
    end
    return r;
  endfunction

  logic [W:0] dr_r, dr_i;
  assign dr_r = div_fin({dq_r[DW-2:0], qb_r}, neg_r);
  assign dr_i = div_fin({dq_i[DW-2:0], qb_i}, neg_i);

  assign status.func     = func;
  assign status.div_last = (cnt == CW'(1));
  assign status.den_zero = (den == '0);

  assign out_item.result_real = 32'(acc_r);
  assign out_item.result_imag = 32'(acc_i);
  assign out_item.error       = err;
  assign out_item.saturated   = sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_r <= '0;
      acc_i <= '0;
      err   <= 1'b0;
      sat   <= 1'b0;
    end else begin
      case (cmd.op)
        cacc_pkg::OP_CAPTURE: begin
          func <= in_item.func;
          x_r  <= W'(in_item.operand_real);
          x_i  <= W'(in_item.operand_imag);
        end
        cacc_pkg::OP_SIMPLE: begin
          case (func)
            cacc_pkg::FUNC_LOAD: begin
              acc_r <= x_r; acc_i <= x_i; err <= 1'b0; sat <= 1'b0;
            end
            cacc_pkg::FUNC_ADD, cacc_pkg::FUNC_SUB: begin
              acc_r <= sr_r[W-1:0];
              acc_i <= sr_i[W-1:0];
              sat   <= sr_r[W] | sr_i[W];
            end
            default: begin
              acc_r <= x_r; acc_i <= x_i; err <= 1'b1; sat <= 1'b0;
            end
          endcase
        end
        cacc_pkg::OP_PROD: begin
          prod[cmd.prod_sel] <= mp;
          if (cmd.prod_sel == 2'd0) den <= (PW+1)'(xrr);
          if (cmd.prod_sel == 2'd1) den <= den + (PW+1)'(xii);
        end
        cacc_pkg::OP_SUM: begin
          if (func == cacc_pkg::FUNC_MUL) begin
            acc_r <= mr_r[W-1:0];
            acc_i <= mr_i[W-1:0];
            sat   <= mr_r[W] | mr_i[W];
          end else if (den == '0) begin
            err   <= 1'b1;
            sat   <= 1'b1;
            acc_r <= acc_r[W-1] ? WMIN : WMAX;
            acc_i <= acc_i[W-1] ? WMIN : WMAX;
          end else begin
            // Divide numerators: real = ar*xr + ai*xi, imag = ai*xr - ar*xi.
            num_r <= SW'(prod[0]) + SW'(prod[1]);
            num_i <= SW'(prod[3]) - SW'(prod[2]);
          end
        end
        cacc_pkg::OP_DIVINIT: begin
          neg_r <= num_r[SW-1];
          neg_i <= num_i[SW-1];
          dq_r  <= DW'(num_r[SW-1] ? -num_r : num_r) << FRAC_BITS;
          dq_i  <= DW'(num_i[SW-1] ? -num_i : num_i) << FRAC_BITS;
          rem_r <= '0;
          rem_i <= '0;
          cnt   <= CW'(DW);
        end
        cacc_pkg::OP_DIVSTEP, cacc_pkg::OP_DIVDONE: begin
          rem_r <= qb_r ? tr_r - RW'(den) : tr_r;
          rem_i <= qb_i ? tr_i - RW'(den) : tr_i;
          dq_r  <= {dq_r[DW-2:0], qb_r};
          dq_i  <= {dq_i[DW-2:0], qb_i};
          cnt   <= cnt - CW'(1);
          if (cmd.op == cacc_pkg::OP_DIVDONE) begin
            acc_r <= dr_r[W-1:0];
            acc_i <= dr_i[W-1:0];
            sat   <= dr_r[W] | dr_i[W];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/complex_accumulator_alu.sv =====
// Top level of the running complex accumulator.
//
//   channel  valid      stall      payload
//   in       in_valid   in_stall   in_data  (func, operand_real, operand_imag)
//   out      out_valid  out_stall  out_data (result_real, result_imag, error, saturated)
//
// Load, add, subtract and invalid codes are applied in the decode state and shown
// in the output state. Multiply forms four partial products that share one multiplier.
// Divide runs on the bit-serial restoring divider, at Q16.16 by default.
// One item is in flight at a time; reset clears the accumulator and error flag, and
// the result holds while stalled.
module complex_accumulator_alu #(
  parameter int WORD_BITS = cacc_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cacc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cacc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cacc_pkg::out_item_t out_data
);

  cacc_pkg::dp_cmd_t    cmd;
  cacc_pkg::dp_status_t status;

  cacc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  cacc_dp #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_data)
  );

endmodule

// ===== sim/complex_accumulator_alu_tb.sv =====
// Self-checking testbench for the running complex accumulator.
module complex_accumulator_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] FUNC_FIRST_INVALID = 3'd5;
  localparam logic [2:0] FUNC_MID_INVALID   = 3'd6;
  localparam logic [2:0] FUNC_LAST_INVALID  = 3'd7;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_ONE = 32'sh00010000;
  localparam logic signed [127:0] WIDE_MAX = {{97{1'b0}}, {31{1'b1}}};
  localparam logic signed [127:0] WIDE_MIN = {{97{1'b1}}, {31{1'b0}}};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  cacc_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  cacc_pkg::out_item_t out_data;

  complex_accumulator_alu dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted accumulator state.
  logic signed [31:0] model_re = '0;
  logic signed [31:0] model_im = '0;
  bit                 model_err = 1'b0;

  cacc_pkg::out_item_t pending_results[$];
  int        error_count = 0;
  bit        idle_en = 1'b0;
  int        stall_left = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic signed [31:0] clip_word(input logic signed [127:0] v,
                                                   inout bit clip);
    if (v > WIDE_MAX) begin
      clip = 1'b1;
      return Q_MAX;
    end
    if (v < WIDE_MIN) begin
      clip = 1'b1;
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  // Scaled quotient truncated toward zero, then clipped to the word range.
  function automatic logic signed [31:0] quotient_word(input logic signed [127:0] num,
                                                       input logic [63:0] den,
                                                       inout bit clip);
    logic [127:0] mag;
    logic [127:0] q;
    bit           neg;
    neg = num < 0;
    mag = neg ? -num : num;
    mag = mag << cacc_pkg::FRAC_BITS_DEF;
    q = mag / {64'd0, den};
    if (neg) begin
      if (q > 128'h80000000) begin
        clip = 1'b1;
        return Q_MIN;
      end
      return -q[31:0];
    end
    if (q > 128'h7fffffff) begin
      clip = 1'b1;
      return Q_MAX;
    end
    return q[31:0];
  endfunction

  function automatic cacc_pkg::out_item_t next_accumulator(input cacc_pkg::in_item_t it);
    logic signed [127:0] ar, ai, xr, xi, pr, pi;
    logic [127:0]        den;
    logic signed [31:0]  nr, ni;
    bit                  clip;
    cacc_pkg::out_item_t res;
    ar = model_re;
    ai = model_im;
    xr = it.operand_real;
    xi = it.operand_imag;
    nr = it.operand_real;
    ni = it.operand_imag;
    clip = 1'b0;
    case (it.func)
      cacc_pkg::FUNC_LOAD: model_err = 1'b0;
      cacc_pkg::FUNC_ADD: begin
        nr = clip_word(ar + xr, clip);
        ni = clip_word(ai + xi, clip);
      end
      cacc_pkg::FUNC_SUB: begin
        nr = clip_word(ar - xr, clip);
        ni = clip_word(ai - xi, clip);
      end
      cacc_pkg::FUNC_MUL: begin
        pr = ar * xr - ai * xi;
        pi = ar * xi + ai * xr;
        nr = clip_word(pr >>> cacc_pkg::FRAC_BITS_DEF, clip);
        ni = clip_word(pi >>> cacc_pkg::FRAC_BITS_DEF, clip);
      end
      cacc_pkg::FUNC_DIV: begin
        den = xr * xr + xi * xi;
        if (den == 0) begin
          model_err = 1'b1;
          clip = 1'b1;
          nr = model_re < 0 ? Q_MIN : Q_MAX;
          ni = model_im < 0 ? Q_MIN : Q_MAX;
        end else begin
          nr = quotient_word(ar * xr + ai * xi, den[63:0], clip);
          ni = quotient_word(ai * xr - ar * xi, den[63:0], clip);
        end
      end
      default: model_err = 1'b1;
    endcase
    model_re = nr;
    model_im = ni;
    res.result_real = nr;
    res.result_imag = ni;
    res.error = model_err;
    res.saturated = clip;
    return res;
  endfunction

  task automatic send_item(input logic [2:0] func, input logic [31:0] re,
                           input logic [31:0] im);
    cacc_pkg::in_item_t it;
    int       r, gap;
    it.func = func;
    it.operand_real = re;
    it.operand_imag = im;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(next_accumulator(it));
    gap = 0;
    if (idle_en) begin
      r = $urandom_range(0, 99);
      gap = r < 50 ? 0 : (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40));
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: compare each transfer and drive random stall.
  always @(posedge clk) begin
    cacc_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", out_data.result_real, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_real !== want.result_real)
          report("result_real", out_data.result_real, want.result_real);
        if (out_data.result_imag !== want.result_imag)
          report("result_imag", out_data.result_imag, want.result_imag);
        if (out_data.error !== want.error)
          report("error", out_data.error, want.error);
        if (out_data.saturated !== want.saturated)
          report("saturated", out_data.saturated, want.saturated);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [31:0] random_operand();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 32'h80000) - 32'h40000;
    if (r == 4) begin
      case ($urandom_range(0, 4))
        0: return Q_MAX;
        1: return Q_MIN;
        2: return 32'd0;
        3: return Q_ONE;
        default: return -Q_ONE;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [2:0] random_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return cacc_pkg::FUNC_LOAD;
    if (r < 30) return cacc_pkg::FUNC_ADD;
    if (r < 50) return cacc_pkg::FUNC_SUB;
    if (r < 75) return cacc_pkg::FUNC_MUL;
    if (r < 94) return cacc_pkg::FUNC_DIV;
    return $urandom_range(FUNC_FIRST_INVALID, FUNC_LAST_INVALID);
  endfunction

  task automatic test_load_and_invalid();
    send_item(cacc_pkg::FUNC_LOAD, Q_MAX, Q_MIN);
    send_item(FUNC_FIRST_INVALID, Q_ONE, -Q_ONE);
    send_item(FUNC_MID_INVALID, 32'h12345678, 32'h87654321);
    send_item(FUNC_LAST_INVALID, Q_MIN, Q_MAX);
    send_item(cacc_pkg::FUNC_LOAD, 32'd0, 32'd0);
  endtask

  task automatic test_add_sub_saturation();
    send_item(cacc_pkg::FUNC_LOAD, Q_MAX, Q_MIN);
    send_item(cacc_pkg::FUNC_ADD, Q_ONE, -Q_ONE);
    send_item(cacc_pkg::FUNC_SUB, -Q_ONE, Q_ONE);
    send_item(cacc_pkg::FUNC_SUB, Q_MIN, Q_MAX);
    send_item(cacc_pkg::FUNC_ADD, 32'h00018000, 32'hfffe8000);
  endtask

  task automatic test_multiply();
    send_item(cacc_pkg::FUNC_LOAD, 32'h00020000, 32'hffff0000);
    send_item(cacc_pkg::FUNC_MUL, 32'h00008000, 32'h00000001);
    send_item(cacc_pkg::FUNC_MUL, 32'hffffffff, 32'h00000003);
    send_item(cacc_pkg::FUNC_LOAD, Q_MAX, Q_MAX);
    send_item(cacc_pkg::FUNC_MUL, Q_MAX, Q_MIN);
    send_item(cacc_pkg::FUNC_MUL, Q_MIN, Q_MIN);
  endtask

  task automatic test_divide();
    send_item(cacc_pkg::FUNC_LOAD, 32'h00030000, 32'h00040000);
    send_item(cacc_pkg::FUNC_DIV, 32'h00010000, 32'h00020000);
    send_item(cacc_pkg::FUNC_LOAD, -Q_ONE, Q_ONE);
    send_item(cacc_pkg::FUNC_DIV, 32'd0, 32'd0);
    send_item(cacc_pkg::FUNC_LOAD, Q_MAX, Q_MIN);
    send_item(cacc_pkg::FUNC_DIV, 32'h00000001, 32'd0);
    send_item(cacc_pkg::FUNC_DIV, Q_MIN, Q_MIN);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      idle_en = (i % 300) >= 60;
      send_item(random_func(), random_operand(), random_operand());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_and_invalid();
    test_add_sub_saturation();
    idle_en = 1'b1;
    test_multiply();
    test_divide();
    test_random(1150);
    in_valid <= 1'b0;
    idle_en = 1'b1;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== complex_accumulator_alu.f =====
src/cacc_pkg.sv
src/cacc_ctrl.sv
src/cacc_dp.sv
src/complex_accumulator_alu.sv
sim/complex_accumulator_alu_tb.sv
